// ===== design/hfr_pkg.sv =====
// Shared types, widths, character codes and helpers for the hex frame receiver.
// No dependencies; every other file depends on this package.
package hfr_pkg;

	localparam int unsigned CHAR_W        = 8;
	localparam int unsigned NIB_W         = 4;
	localparam int unsigned FRAME_CHARS   = 18;
	localparam int unsigned POS_W         = $clog2(FRAME_CHARS + 1);
	localparam int unsigned CRC_W         = 8;
	localparam int unsigned CRC_BITS      = 64;
	localparam int unsigned CRC_CNT_W     = $clog2(CRC_BITS);
	localparam int unsigned ANGLE_W       = 16;
	localparam int unsigned SPEED_W       = 8;
	localparam int unsigned DIR_W         = 4;
	localparam int unsigned LIGHT_W       = 12;
	localparam int unsigned ANGLE_SCALE_DEF = 100;

	localparam logic [CRC_W-1:0] CRC_POLY = 8'h9B;
	localparam logic [CRC_W-1:0] CRC_INIT = 8'hFF;

	localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;

	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [NIB_W-1:0]   nib_t;
	typedef logic [ANGLE_W-1:0] angle_t;
	typedef logic [SPEED_W-1:0] speed_t;
	typedef logic [DIR_W-1:0]   dir_t;
	typedef logic [LIGHT_W-1:0] light_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CRC,
		ST_CHK,
		ST_DIV,
		ST_EMIT
	} state_t;

	// Map an ASCII character to its hex value; anything else reads as zero.
	function automatic nib_t hex_nibble(input char_t c);
		char_t d;
		begin
			d = '0;
			if (c >= CH_0 && c <= CH_9) begin
				d = c - CH_0;
			end else if (c >= CH_UA && c <= CH_UF) begin
				d = c - CH_UA + 8'd10;
			end else if (c >= CH_LA && c <= CH_LF) begin
				d = c - CH_LA + 8'd10;
			end
			return d[NIB_W-1:0];
		end
	endfunction

endpackage

// ===== design/hfr_if.sv =====
// Handshake channels of the hex frame receiver: character input and result output.
// Depends on hfr_pkg for the payload types.
interface hfr_char_if;
	logic           valid;
	logic           ready;
	hfr_pkg::char_t char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface hfr_result_if;
	logic            valid;
	logic            ready;
	logic            crc_fault;
	hfr_pkg::angle_t azimuth;
	hfr_pkg::angle_t elevation;
	hfr_pkg::speed_t wind_speed;
	hfr_pkg::dir_t   wind_direction;
	hfr_pkg::light_t light_level;

	modport source (output valid, output crc_fault, output azimuth, output elevation,
		output wind_speed, output wind_direction, output light_level, input ready);
	modport sink   (input valid, input crc_fault, input azimuth, input elevation,
		input wind_speed, input wind_direction, input light_level, output ready);
endinterface

// ===== design/hfr_crc_serial.sv =====
// Bit-serial CRC-8 engine, MSB first, one message bit per enabled cycle.
// Depends on hfr_pkg for the polynomial and initial value.
module hfr_crc_serial (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       init,
	input  logic                       shift,
	input  logic                       din,
	output logic [hfr_pkg::CRC_W-1:0]  crc
);
	import hfr_pkg::*;

	logic [CRC_W-1:0] crc_q;
	logic             fb;

	assign fb  = crc_q[CRC_W-1] ^ din;
	assign crc = crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (init) begin
			crc_q <= CRC_INIT;
		end else if (shift) begin
			crc_q <= {crc_q[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
		end
	end

endmodule

// ===== design/hfr_div_serial.sv =====
// Restoring divider by a constant, one quotient bit per cycle.
// Depends on hfr_pkg only through the import convention of the project.
module hfr_div_serial #(
	parameter int unsigned W       = 16,
	parameter int unsigned DIVISOR = 100
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	output logic         busy,
	output logic [W-1:0] quotient
);
	import hfr_pkg::*;

	localparam int unsigned CNT_W = (W > 1) ? $clog2(W) : 1;
	localparam logic [W-1:0] Div  = W'(DIVISOR);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [W:0]       trial;
	logic             fits;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial    = {rem_q, quo_q[W-1]};
	assign fits     = trial >= {1'b0, Div};
	assign busy     = busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? W'(trial - {1'b0, Div}) : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

endmodule

// ===== design/hex_frame_receiver_crc8.sv =====
// Hex frame receiver: ASCII-hex frames with device ID filter and CRC-8/CDMA2000 check.
// Top level; uses hfr_pkg, hfr_if, hfr_crc_serial and hfr_div_serial.
//
// Usage:
//   chars   - one received character word per handshake (valid/ready).
//   results - one word per closed frame: crc_fault plus the last good
//             azimuth, elevation, wind speed, wind direction and light level.
//   cfg_we / cfg_data - write the device ID; write only while idle.
// A closing '}' starts a bit-serial CRC pass over the 64 stored payload bits,
// then a check step, then, on a good CRC, a bit-serial division of both
// angles by ANGLE_SCALE, after which the new values are kept, and then a
// load of the output register; a CRC fault skips the division. chars.ready
// is low from the closing character until the output register is loaded.
// A result waits in the output register while results.ready is low; the
// block keeps taking characters, and only the next closing character stalls
// in its last step until the waiting word is taken.
// Reset clears the device ID, the frame state, the nibble store and the
// kept values to zero and leaves no result pending.
module hex_frame_receiver_crc8 #(
	parameter int unsigned ANGLE_SCALE = hfr_pkg::ANGLE_SCALE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hfr_char_if.sink              chars,
	hfr_result_if.source          results,
	input  logic                  cfg_we,
	input  hfr_pkg::char_t        cfg_data
);
	import hfr_pkg::*;

	state_t state_q, state_d;

	char_t              device_id_q;
	logic               in_frame_q;
	logic [POS_W-1:0]   char_pos_q;
	nib_t               store_q [FRAME_CHARS];
	logic [CRC_CNT_W-1:0] crc_cnt_q;
	logic               fault_q;

	angle_t kept_az_q, kept_el_q;
	speed_t kept_ws_q;
	dir_t   kept_wd_q;
	light_t kept_ll_q;

	logic   out_valid_q;
	logic   out_fault_q;
	angle_t out_az_q, out_el_q;
	speed_t out_ws_q;
	dir_t   out_wd_q;
	light_t out_ll_q;

	logic       accept;
	logic       close_acc;
	nib_t       nib;
	logic       id_bad;
	nib_t       crc_nib;
	logic       crc_bit;
	logic [CRC_W-1:0] crc;
	logic       crc_ok;
	logic       crc_last;
	angle_t     raw_az, raw_el;
	angle_t     quo_az, quo_el;
	logic       busy_az, busy_el;
	logic       div_busy;

	logic in_ready, crc_shift, div_start, kept_load, out_load;

	assign accept    = chars.valid && in_ready;
	assign close_acc = accept && in_frame_q && chars.char_code == CH_CLOSE;
	assign nib       = hex_nibble(chars.char_code);
	// Second ID digit arriving: compare both digits against the device ID.
	assign id_bad    = char_pos_q == POS_W'(1) && {store_q[0], nib} != device_id_q;

	assign crc_nib  = store_q[{1'b0, crc_cnt_q[CRC_CNT_W-1:2]}];
	assign crc_bit  = crc_nib[~crc_cnt_q[1:0]];
	assign crc_last = crc_cnt_q == CRC_CNT_W'(CRC_BITS - 1);
	assign crc_ok   = crc == {store_q[16], store_q[17]};

	assign raw_az   = {store_q[2], store_q[3], store_q[4], store_q[5]};
	assign raw_el   = {store_q[6], store_q[7], store_q[8], store_q[9]};
	assign div_busy = busy_az || busy_el;

	hfr_crc_serial u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.init   (close_acc),
		.shift  (crc_shift),
		.din    (crc_bit),
		.crc    (crc)
	);

	hfr_div_serial #(.W(ANGLE_W), .DIVISOR(ANGLE_SCALE)) u_div_az (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (raw_az),
		.busy     (busy_az),
		.quotient (quo_az)
	);

	hfr_div_serial #(.W(ANGLE_W), .DIVISOR(ANGLE_SCALE)) u_div_el (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (raw_el),
		.busy     (busy_el),
		.quotient (quo_el)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (close_acc) begin
					state_d = ST_CRC;
				end
			end
			ST_CRC: begin
				if (crc_last) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				state_d = crc_ok ? ST_DIV : ST_EMIT;
			end
			ST_DIV: begin
				if (!div_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || results.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		crc_shift = 1'b0;
		div_start = 1'b0;
		kept_load = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: in_ready  = 1'b1;
			ST_CRC:  crc_shift = 1'b1;
			ST_CHK:  div_start = crc_ok;
			ST_DIV:  kept_load = !div_busy;
			ST_EMIT: out_load  = !out_valid_q || results.ready;
			default: in_ready  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			device_id_q <= '0;
			in_frame_q  <= 1'b0;
			char_pos_q  <= '0;
			crc_cnt_q   <= '0;
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < FRAME_CHARS; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				device_id_q <= cfg_data;
			end
			if (accept) begin
				if (chars.char_code == CH_OPEN) begin
					in_frame_q <= 1'b1;
					char_pos_q <= '0;
					for (int i = 0; i < FRAME_CHARS; i++) begin
						store_q[i] <= '0;
					end
				end else if (in_frame_q) begin
					if (chars.char_code == CH_CLOSE) begin
						in_frame_q <= 1'b0;
						char_pos_q <= '0;
					end else if (char_pos_q < POS_W'(FRAME_CHARS)) begin
						store_q[char_pos_q] <= nib;
						if (id_bad) begin
							// drop the frame; the store keeps its contents
							in_frame_q <= 1'b0;
							char_pos_q <= '0;
						end else begin
							char_pos_q <= char_pos_q + 1'b1;
						end
					end
				end
			end
			if (close_acc) begin
				crc_cnt_q <= '0;
			end else if (crc_shift) begin
				crc_cnt_q <= crc_cnt_q + 1'b1;
			end
			if (state_q == ST_CHK) begin
				fault_q <= !crc_ok;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_az_q <= '0;
			kept_el_q <= '0;
			kept_ws_q <= '0;
			kept_wd_q <= '0;
			kept_ll_q <= '0;
		end else if (kept_load) begin
			kept_az_q <= quo_az;
			kept_el_q <= quo_el;
			kept_ws_q <= {store_q[10], store_q[11]};
			kept_wd_q <= store_q[12];
			kept_ll_q <= {store_q[13], store_q[14], store_q[15]};
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_fault_q <= fault_q;
			out_az_q    <= kept_az_q;
			out_el_q    <= kept_el_q;
			out_ws_q    <= kept_ws_q;
			out_wd_q    <= kept_wd_q;
			out_ll_q    <= kept_ll_q;
		end
	end

	assign chars.ready            = in_ready;
	assign results.valid          = out_valid_q;
	assign results.crc_fault      = out_fault_q;
	assign results.azimuth        = out_az_q;
	assign results.elevation      = out_el_q;
	assign results.wind_speed     = out_ws_q;
	assign results.wind_direction = out_wd_q;
	assign results.light_level    = out_ll_q;

`ifndef SYNTHESIS
	a_close_starts_crc: assert property (@(posedge clk) disable iff (!arst_n)
		close_acc |=> state_q == ST_CRC)
		else $error("closing character did not start the CRC pass");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		char_pos_q <= POS_W'(FRAME_CHARS))
		else $error("character position past the nibble store");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_DIV)
		else $error("divider running outside the divide state");

	a_crc_then_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CRC && crc_last) |=> state_q == ST_CHK)
		else $error("CRC pass did not end in the check state");
`endif

endmodule

// ===== dv/hfr_report_checker.sv =====
// Frame report checker for the hex frame receiver: follows the character and
// device ID traffic, works out every frame report and compares it on arrival.
// Depends on hfr_pkg and on the channel interfaces of hfr_if.
module hfr_report_checker #(
	parameter int unsigned ANGLE_SCALE = hfr_pkg::ANGLE_SCALE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	hfr_char_if            chars,
	hfr_result_if          results,
	input  logic           cfg_we,
	input  hfr_pkg::char_t cfg_data,
	output int             mismatch_count,
	output int             reports_owed
);
	import hfr_pkg::*;

	typedef struct packed {
		logic   crc_fault;
		angle_t azimuth;
		angle_t elevation;
		speed_t wind_speed;
		dir_t   wind_direction;
		light_t light_level;
	} frame_report_t;

	frame_report_t report_q[$];
	char_t         station_id;
	logic          open_frame;
	int unsigned   fill;
	nib_t          digits [FRAME_CHARS];
	angle_t        last_azimuth;
	angle_t        last_elevation;
	speed_t        last_wind_speed;
	dir_t          last_wind_direction;
	light_t        last_light_level;
	int            errors = 0;

	function automatic nib_t char_value(input char_t c);
		if (c >= CH_0 && c <= CH_9) begin
			return c[3:0];
		end
		// letters a-f and A-F carry 1..6 in the low nibble
		if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
			return c[3:0] + 4'd9;
		end
		return '0;
	endfunction

	function automatic logic [15:0] digits_at(input int first, input int count);
		logic [15:0] v;
		v = '0;
		for (int i = 0; i < count; i++) begin
			v = (v << 4) | 16'(digits[first + i]);
		end
		return v;
	endfunction

	function automatic logic [7:0] payload_crc();
		logic [7:0] crc;
		crc = CRC_INIT;
		for (int b = 0; b < 8; b++) begin
			crc = crc ^ {digits[2 * b], digits[2 * b + 1]};
			for (int k = 0; k < 8; k++) begin
				crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
			end
		end
		return crc;
	endfunction

	task automatic absorb_char(input char_t c);
		frame_report_t rep;
		if (c == CH_OPEN) begin
			open_frame = 1'b1;
			fill = 0;
			foreach (digits[i]) digits[i] = '0;
		end else if (open_frame && c != CH_CLOSE) begin
			if (fill < FRAME_CHARS) begin
				digits[fill] = char_value(c);
				fill++;
				// drop a frame addressed to another station
				if (fill == 2 && digits_at(0, 2) != 16'(station_id)) begin
					open_frame = 1'b0;
					fill = 0;
				end
			end
		end else if (open_frame) begin
			open_frame = 1'b0;
			fill = 0;
			rep.crc_fault = (16'(payload_crc()) != digits_at(16, 2));
			if (!rep.crc_fault) begin
				last_azimuth        = angle_t'(digits_at(2, 4) / ANGLE_SCALE);
				last_elevation      = angle_t'(digits_at(6, 4) / ANGLE_SCALE);
				last_wind_speed     = speed_t'(digits_at(10, 2));
				last_wind_direction = digits[12];
				last_light_level    = light_t'(digits_at(13, 3));
			end
			rep.azimuth        = last_azimuth;
			rep.elevation      = last_elevation;
			rep.wind_speed     = last_wind_speed;
			rep.wind_direction = last_wind_direction;
			rep.light_level    = last_light_level;
			report_q.push_back(rep);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		frame_report_t got;
		frame_report_t want;
		if (!arst_n) begin
			station_id          = '0;
			open_frame          = 1'b0;
			fill                = 0;
			foreach (digits[i]) digits[i] = '0;
			last_azimuth        = '0;
			last_elevation      = '0;
			last_wind_speed     = '0;
			last_wind_direction = '0;
			last_light_level    = '0;
			report_q.delete();
			mismatch_count <= errors;
			reports_owed   <= 0;
		end else begin
			// compare before absorbing: a report never leaves on its closing edge
			if (results.valid && results.ready) begin
				got.crc_fault      = results.crc_fault;
				got.azimuth        = results.azimuth;
				got.elevation      = results.elevation;
				got.wind_speed     = results.wind_speed;
				got.wind_direction = results.wind_direction;
				got.light_level    = results.light_level;
				if (report_q.size() == 0) begin
					$display("%0t: report without a closed frame, expected none got %h",
						$time, got);
					errors++;
				end else begin
					want = report_q.pop_front();
					check_field("crc_fault", 16'(want.crc_fault), 16'(got.crc_fault));
					check_field("azimuth", want.azimuth, got.azimuth);
					check_field("elevation", want.elevation, got.elevation);
					check_field("wind_speed", 16'(want.wind_speed), 16'(got.wind_speed));
					check_field("wind_direction", 16'(want.wind_direction),
						16'(got.wind_direction));
					check_field("light_level", 16'(want.light_level), 16'(got.light_level));
				end
			end
			if (cfg_we) begin
				station_id = cfg_data;
			end
			if (chars.valid && chars.ready) begin
				absorb_char(chars.char_code);
			end
			mismatch_count <= errors;
			reports_owed   <= report_q.size();
		end
	end

endmodule

// ===== dv/hex_frame_receiver_crc8_tb.sv =====
// Top of the hex frame receiver bench: clock, reset, device ID phases and the
// character stream of well-formed, damaged and noisy frames, with random stalls.
// Depends on hfr_pkg, hfr_if, the receiver RTL and hfr_report_checker.
module hex_frame_receiver_crc8_tb;
	import hfr_pkg::*;

	localparam int unsigned ANGLE_SCALE  = ANGLE_SCALE_DEF;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          SETTLE_TICKS = 120;
	localparam int          PHASE_CHARS  = 225;
	localparam int          PHASES       = 6;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cfg_we;
	char_t cfg_data;
	int    mismatch_count;
	int    reports_owed;

	char_t line_q[$];
	nib_t  nibs [FRAME_CHARS];
	logic  junk [FRAME_CHARS];
	char_t dev_id;
	logic  feed_burst;
	logic  drain_burst;
	int    phase_sent;

	hfr_char_if   chars_if();
	hfr_result_if res_if();

	hex_frame_receiver_crc8 #(
		.ANGLE_SCALE (ANGLE_SCALE)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars_if),
		.results  (res_if),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	hfr_report_checker #(
		.ANGLE_SCALE (ANGLE_SCALE)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.chars          (chars_if),
		.results        (res_if),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.reports_owed   (reports_owed)
	);

	always #1 clk = ~clk;

	function automatic char_t digit_char(input nib_t n);
		if (n < 4'd10) begin
			return CH_0 + char_t'(n);
		end
		return ((($urandom_range(0, 1) != 0) ? CH_UA : CH_LA) + char_t'(n)) - 8'd10;
	endfunction

	function automatic char_t junk_char();
		char_t c;
		do begin
			c = char_t'($urandom_range(0, 255));
		end while ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF)
			|| (c >= CH_LA && c <= CH_LF) || c == CH_OPEN || c == CH_CLOSE);
		return c;
	endfunction

	task automatic seal_frame();
		logic [7:0] crc;
		crc = CRC_INIT;
		for (int b = 0; b < 8; b++) begin
			crc = crc ^ {nibs[2 * b], nibs[2 * b + 1]};
			for (int k = 0; k < 8; k++) begin
				crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
			end
		end
		nibs[16] = crc[7:4];
		nibs[17] = crc[3:0];
	endtask

	// Junk characters read as zero, so their digits are zeroed before sealing.
	task automatic make_frame(input char_t id, input bit with_junk);
		int unsigned fill_mode;
		fill_mode = $urandom_range(0, 9);
		nibs[0] = id[7:4];
		nibs[1] = id[3:0];
		junk[0] = 1'b0;
		junk[1] = 1'b0;
		junk[16] = 1'b0;
		junk[17] = 1'b0;
		for (int i = 2; i < 16; i++) begin
			case (fill_mode)
				0: nibs[i] = 4'h0;
				1: nibs[i] = 4'hF;
				default: nibs[i] = nib_t'($urandom_range(0, 15));
			endcase
			junk[i] = with_junk && ($urandom_range(0, 3) == 0);
			if (junk[i]) begin
				nibs[i] = 4'h0;
			end
		end
		seal_frame();
	endtask

	task automatic queue_frame(input int count, input bit close);
		line_q.push_back(CH_OPEN);
		for (int i = 0; i < count; i++) begin
			line_q.push_back(junk[i] ? junk_char() : digit_char(nibs[i]));
		end
		if (close) begin
			line_q.push_back(CH_CLOSE);
		end
	endtask

	task automatic queue_random_frame();
		int unsigned kind;
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			make_frame(dev_id, 1'b0);
			queue_frame(18, 1'b1);
		end else if (kind < 65) begin
			make_frame(dev_id, 1'b0);
			nibs[16 + $urandom_range(0, 1)] ^= nib_t'($urandom_range(1, 15));
			queue_frame(18, 1'b1);
		end else if (kind < 72) begin
			make_frame(dev_id ^ char_t'($urandom_range(1, 255)), 1'b0);
			queue_frame($urandom_range(2, 18), 1'b1);
		end else if (kind < 78) begin
			make_frame(dev_id, 1'b0);
			queue_frame($urandom_range(0, 17), 1'b1);
		end else if (kind < 84) begin
			// overlong: the tail past the last digit must be ignored
			make_frame(dev_id, 1'b0);
			queue_frame(18, 1'b0);
			repeat ($urandom_range(1, 4)) begin
				line_q.push_back(($urandom_range(0, 1) != 0) ?
					digit_char(nib_t'($urandom_range(0, 15))) : junk_char());
			end
			line_q.push_back(CH_CLOSE);
		end else if (kind < 90) begin
			make_frame(($urandom_range(0, 1) != 0) ? dev_id : char_t'($urandom_range(0, 255)),
				1'b0);
			queue_frame($urandom_range(0, 17), 1'b0);
			make_frame(dev_id, 1'b0);
			queue_frame(18, 1'b1);
		end else if (kind < 95) begin
			make_frame(dev_id, 1'b1);
			queue_frame(18, 1'b1);
		end else begin
			repeat ($urandom_range(1, 6)) begin
				line_q.push_back(char_t'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic send_char(input char_t c);
		int gap;
		if ($urandom_range(0, 31) == 0) begin
			feed_burst = ~feed_burst;
		end
		gap = feed_burst ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= c;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
	endtask

	task automatic send_queued();
		while (line_q.size() != 0) begin
			send_char(line_q.pop_front());
			phase_sent++;
		end
	endtask

	// Hold until every report is in, then let any frame work run out.
	task automatic settle();
		chars_if.valid <= 1'b0;
		@(posedge clk);
		while (reports_owed != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_station_id(input char_t v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		dev_id = v;
	endtask

	// result side: random stall before taking each word
	initial begin
		int gap;
		res_if.ready = 1'b0;
		drain_burst = 1'b0;
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				drain_burst = ~drain_burst;
			end
			gap = drain_burst ? 0 : $urandom_range(0, 16);
			if (gap != 0) begin
				res_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (!res_if.valid) @(posedge clk);
		end
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_data           = '0;
		chars_if.valid     = 1'b0;
		chars_if.char_code = '0;
		feed_burst         = 1'b0;
		dev_id             = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: write_station_id(8'h00);
				1: write_station_id(8'hFF);
				2: write_station_id(CH_OPEN);
				3: write_station_id(8'hA5);
				default: write_station_id(char_t'($urandom_range(0, 255)));
			endcase
			phase_sent = 0;
			if (p == 0) begin
				// stray close and noise outside a frame
				line_q.push_back(CH_CLOSE);
				line_q.push_back(junk_char());
				line_q.push_back(8'hFF);
				// all-ones payload with a good CRC
				make_frame(dev_id, 1'b0);
				for (int i = 2; i < 16; i++) nibs[i] = 4'hF;
				seal_frame();
				queue_frame(18, 1'b1);
				// wrong station, then an empty frame
				line_q.push_back(CH_OPEN);
				line_q.push_back(digit_char(4'h0));
				line_q.push_back(digit_char(4'h1));
				line_q.push_back(CH_OPEN);
				line_q.push_back(CH_CLOSE);
				send_queued();
			end
			while (phase_sent < PHASE_CHARS) begin
				queue_random_frame();
				send_queued();
			end
		end
		settle();
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		for (int cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== hex_frame_receiver_crc8.f =====
design/hfr_pkg.sv
design/hfr_if.sv
design/hfr_crc_serial.sv
design/hfr_div_serial.sv
design/hex_frame_receiver_crc8.sv
dv/hfr_report_checker.sv
dv/hex_frame_receiver_crc8_tb.sv
